>>> src/gcfa_pkg.sv
// Package for the greedy capacitated facility assigner.
// Holds the sizes, the item kind codes, the state encoding and the entry layout.
// No dependencies.
package gcfa_pkg;

    localparam int NUM_FACILITIES = 2048;
    localparam int FAC_AW         = $clog2(NUM_FACILITIES);

    localparam int FAC_W   = 11;
    localparam int CAP_W   = 24;
    localparam int COST_W  = 32;
    localparam int TOTAL_W = 48;

    // Input item kinds (tuser)
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_COST    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_FIN
    } t_state;

    // One facility record in the memory
    typedef struct packed {
        logic                is_open;
        logic [CAP_W-1:0]    cap;
        logic [COST_W-1:0]   setup;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Input transaction, unpacked from the stream
    typedef struct packed {
        logic [1:0]          kind;
        logic [FAC_W-1:0]    facility;
        logic [CAP_W-1:0]    capacity;
        logic [COST_W-1:0]   setup_cost;
        logic [CAP_W-1:0]    demand;
        logic [COST_W-1:0]   travel_cost;
        logic                row_end;
    } t_item;

endpackage

>>> src/gcfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module gcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/greedy_capacitated_facility_assign_top.sv
// Top level of the greedy capacitated facility assigner.
// Depends on gcfa_pkg and gcfa_ram.
//
// The block keeps one record per facility (open mark, remaining capacity,
// setup cost) in a single RAM with a registered read port. A load
// transaction writes a record and clears its open mark; a restart clears the
// running total; cost transactions stream one customer's travel costs, and
// the cheapest facility whose remaining capacity covers the demand is kept
// (ties keep the earliest). On a tlast cost transaction one result is produced:
// the chosen facility, found, newly_opened and the saturating 48-bit total.
// Work is one transaction at a time, paced by the record RAM read latency:
// load, restart and unused kinds finish when accepted; a cost element is
// accepted with a RAM read, then compared against the read data; a row end
// then reads the chosen record again, writes it back and registers the
// result, waiting while the result register is still full. The result register
// lets the next transaction enter while a result still waits. After reset
// a clearing pass zeroes all NUM_FACILITIES (2048) records;
// o_s_axis_tready stays low during it.
module greedy_capacitated_facility_assign_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [10:0] facility, [34:11] capacity, [66:35] setup_cost,
    // [90:67] demand, [122:91] travel_cost, [127:123] zero
    input  logic [127:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   i_s_axis_tuser,
    // row_end
    input  logic         i_s_axis_tlast,
    // Result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [10:0] chosen_facility, [58:11] total_cost, [63:59] zero
    output logic [63:0]  o_m_axis_tdata,
    // [0] found, [1] newly_opened
    output logic [1:0]   o_m_axis_tuser
);
    import gcfa_pkg::*;

    t_state r_state, n_state;

    t_item  w_item, r_item;
    logic   w_s_accept;

    // Row candidate state
    logic [COST_W-1:0]  r_best_cost, n_best_cost;
    logic [FAC_W-1:0]   r_best_index, n_best_index;
    logic               r_have_best, n_have_best;
    logic [TOTAL_W-1:0] r_total;

    logic [FAC_AW-1:0]  r_clr_addr;

    // Result register
    logic               r_out_valid;
    logic [FAC_W-1:0]   r_out_fac;
    logic               r_out_found;
    logic               r_out_opened;
    logic [TOTAL_W-1:0] r_out_total;

    // RAM port signals
    logic               mem_we, mem_re;
    logic [FAC_AW-1:0]  mem_waddr, mem_raddr;
    t_entry             mem_wdata, mem_rdata;

    logic               w_out_free;
    logic               w_fac_ok;
    logic               w_cand;
    logic               w_fin_go;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_new_total;
    logic [CAP_W-1:0]   w_new_cap;

    assign w_item = '{
        kind:        i_s_axis_tuser,
        facility:    i_s_axis_tdata[10:0],
        capacity:    i_s_axis_tdata[34:11],
        setup_cost:  i_s_axis_tdata[66:35],
        demand:      i_s_axis_tdata[90:67],
        travel_cost: i_s_axis_tdata[122:91],
        row_end:     i_s_axis_tlast
    };

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fin_go        = (r_state == S_FIN) && w_out_free;

    gcfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FACILITIES)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Evaluation of the registered cost element against its record
    always_comb begin
        w_fac_ok = 32'(r_item.facility) < 32'(NUM_FACILITIES);
        w_cand   = w_fac_ok && (mem_rdata.cap >= r_item.demand) &&
                   (!r_have_best || (r_item.travel_cost < r_best_cost));
    end

    // Row-end update of the chosen record
    always_comb begin
        w_sum       = {1'b0, r_total} + (TOTAL_W+1)'(mem_rdata.setup);
        w_new_total = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
        w_new_cap   = (mem_rdata.cap >= r_item.demand) ?
                      (mem_rdata.cap - r_item.demand) : '0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == FAC_AW'(NUM_FACILITIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_s_accept && (w_item.kind == KIND_COST)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = r_item.row_end ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM control and candidate update
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_clr_addr;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = FAC_AW'(w_item.facility);
        n_best_cost  = r_best_cost;
        n_best_index = r_best_index;
        n_have_best  = r_have_best;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                if (w_s_accept && (w_item.kind == KIND_LOAD) &&
                    (32'(w_item.facility) < 32'(NUM_FACILITIES))) begin
                    mem_we    = 1'b1;
                    mem_waddr = FAC_AW'(w_item.facility);
                    mem_wdata = '{is_open: 1'b0, cap: w_item.capacity,
                                  setup: w_item.setup_cost};
                end
                mem_re = w_s_accept && (w_item.kind == KIND_COST);
            end
            S_EVAL: begin
                if (w_cand) begin
                    n_best_cost  = r_item.travel_cost;
                    n_best_index = r_item.facility;
                    n_have_best  = 1'b1;
                end
                // fetch the chosen record for the row-end update
                mem_re    = r_item.row_end && n_have_best;
                mem_raddr = FAC_AW'(n_best_index);
            end
            S_FIN: begin
                if (w_out_free) begin
                    mem_we       = r_have_best;
                    mem_waddr    = FAC_AW'(r_best_index);
                    mem_wdata    = '{is_open: 1'b1, cap: w_new_cap,
                                     setup: mem_rdata.setup};
                    n_best_cost  = '1;
                    n_best_index = '0;
                    n_have_best  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_best_cost  <= '1;
            r_best_index <= '0;
            r_have_best  <= 1'b0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_best_cost  <= n_best_cost;
            r_best_index <= n_best_index;
            r_have_best  <= n_have_best;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + FAC_AW'(1);
            end
            if (w_s_accept && (w_item.kind == KIND_RESTART)) begin
                r_total <= '0;
            end
            if (w_fin_go && r_have_best && !mem_rdata.is_open) begin
                r_total <= w_new_total;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_item <= w_item;
        end
        if (w_fin_go) begin
            r_out_fac    <= r_have_best ? r_best_index : '0;
            r_out_found  <= r_have_best;
            r_out_opened <= r_have_best && !mem_rdata.is_open;
            r_out_total  <= (r_have_best && !mem_rdata.is_open) ? w_new_total : r_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_total, r_out_fac};
    assign o_m_axis_tuser  = {r_out_opened, r_out_found};

    // A new result only appears after the row-end step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside row-end step");

    // A not-found result carries no facility and opens nothing
    a_not_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[10:0] == '0) && !o_m_axis_tuser[1])
        else $error("not-found result with facility or open flag");

    // An accepted cost element is evaluated in the next cycle
    a_cost_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && (i_s_axis_tuser == KIND_COST)) |=> (r_state == S_EVAL))
        else $error("cost element not evaluated");

    // No record write while a fetched record is being evaluated
    a_no_write_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> !mem_we)
        else $error("record write during evaluation");

endmodule

>>> sim/tb_greedy_capacitated_facility_assign_top.sv
// Self-checking testbench for greedy_capacitated_facility_assign_top.
// Drives the input stream from a directed table and random customer rows, and checks
// each result against a behavioral predictor. Depends on gcfa_pkg and the RTL.
module tb_greedy_capacitated_facility_assign_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcfa_pkg::*;

    // Kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 400;   // random cost/load/restart transactions
    localparam int CALM_AFTER   = 340;   // no idling on either side past this point
    localparam int OPEN_PAIRS   = 12;    // back-to-back load+open pairs at the end
    localparam int HOLD_CYCLES  = 300;   // one long downstream stall
    localparam int DRAIN_CYCLES = 16;    // idle margin after the last expected result
    localparam logic [TOTAL_W-1:0] TOTAL_ONES = '1;

    // One customer assignment as it leaves the block
    typedef struct packed {
        logic [FAC_W-1:0]   fac;
        logic               found;
        logic               fresh;
        logic [TOTAL_W-1:0] total;
    } t_assign_res;

    // Directed stimulus row; pinned rows carry a hand-written expectation
    typedef struct packed {
        t_item       item;
        logic        pinned;
        t_assign_res want;
    } t_plan_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [127:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [63:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    greedy_capacitated_facility_assign_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: facility records plus the per-row best candidate
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]   cap_left  [NUM_FACILITIES];
    logic [COST_W-1:0]  open_cost [NUM_FACILITIES];
    logic               fac_open  [NUM_FACILITIES];
    logic [COST_W-1:0]  best_travel;
    logic [FAC_W-1:0]   best_fac;
    logic               have_pick;
    logic [TOTAL_W-1:0] total_cost;

    // Stimulus bookkeeping: cost items only ever target loaded facilities
    bit                 fac_loaded [NUM_FACILITIES];
    int                 loaded_list [$];

    t_assign_res        pending_assignments [$];
    int                 mismatches = 0;
    int                 assignments_seen = 0;
    int                 counted_items = 0;
    bit                 calm = 1'b0;

    // Applies one accepted transaction to the predictor; returns 1 with the
    // expected assignment when the transaction closes a customer row.
    function automatic bit assign_step(input t_item it, output t_assign_res res);
        logic [TOTAL_W:0] sum;
        res = '0;
        case (it.kind)
            KIND_LOAD: begin
                if (int'(it.facility) < NUM_FACILITIES) begin
                    cap_left[it.facility]  = it.capacity;
                    open_cost[it.facility] = it.setup_cost;
                    fac_open[it.facility]  = 1'b0;
                end
                return 1'b0;
            end
            KIND_RESTART: begin
                total_cost = '0;
                return 1'b0;
            end
            KIND_COST: begin
                // strict less-than: on a tie the earlier candidate stays
                if (int'(it.facility) < NUM_FACILITIES && cap_left[it.facility] >= it.demand &&
                    (!have_pick || it.travel_cost < best_travel)) begin
                    best_travel = it.travel_cost;
                    best_fac    = it.facility;
                    have_pick   = 1'b1;
                end
                if (!it.row_end)
                    return 1'b0;
                if (have_pick) begin
                    res.fac   = best_fac;
                    res.found = 1'b1;
                    if (!fac_open[best_fac]) begin
                        sum        = {1'b0, total_cost} + open_cost[best_fac];
                        total_cost = sum[TOTAL_W] ? TOTAL_ONES : sum[TOTAL_W-1:0];
                        fac_open[best_fac] = 1'b1;
                        res.fresh  = 1'b1;
                    end
                    // uses the row-end demand and floors at zero
                    if (cap_left[best_fac] >= it.demand)
                        cap_left[best_fac] = cap_left[best_fac] - it.demand;
                    else
                        cap_left[best_fac] = '0;
                end
                res.total   = total_cost;
                best_travel = '1;
                best_fac    = '0;
                have_pick   = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_item mk_item(input logic [1:0] kind, input logic [FAC_W-1:0] fac,
                                      input logic [CAP_W-1:0] cap,
                                      input logic [COST_W-1:0] setup,
                                      input logic [CAP_W-1:0] dem,
                                      input logic [COST_W-1:0] travel, input logic last);
        t_item it;
        it.kind        = kind;
        it.facility    = fac;
        it.capacity    = cap;
        it.setup_cost  = setup;
        it.demand      = dem;
        it.travel_cost = travel;
        it.row_end     = last;
        return it;
    endfunction

    function automatic t_assign_res mk_res(input logic [FAC_W-1:0] fac, input logic found,
                                           input logic fresh, input logic [TOTAL_W-1:0] total);
        t_assign_res r;
        r.fac   = fac;
        r.found = found;
        r.fresh = fresh;
        r.total = total;
        return r;
    endfunction

    // Random field values, biased so that capacity checks go both ways
    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 7))
            0:       return CAP_W'($urandom);
            1:       return '0;
            default: return CAP_W'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] pick_demand();
        case ($urandom_range(0, 7))
            0:       return CAP_W'($urandom);
            1:       return '0;
            default: return CAP_W'($urandom_range(0, 1200));
        endcase
    endfunction

    function automatic logic [COST_W-1:0] pick_travel();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return '1;
            2, 3:    return COST_W'($urandom_range(0, 3)); // frequent ties
            default: return COST_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: present one transaction and hold it until the block takes it.
    // Called at a rising edge; returns at the edge of acceptance.
    // ------------------------------------------------------------------
    task automatic offer(input t_item it);
        s_valid <= 1'b1;
        // tdata: facility, capacity, setup_cost, demand, travel_cost, zero pad
        s_data  <= {5'b0, it.travel_cost, it.demand, it.setup_cost, it.capacity,
                    it.facility};
        s_user  <= it.kind;
        s_last  <= it.row_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_checked(input t_item it);
        t_assign_res r;
        offer(it);
        if (it.kind != KIND_UNUSED)
            counted_items++;
        if (assign_step(it, r))
            pending_assignments.push_back(r);
    endtask

    // Random idle gap for the sender, none once the run is calm
    task automatic rest_sender();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // A transaction outside a row: facility load, restart or an unused kind
    task automatic stray_item();
        int          pick;
        int          fac;
        t_item       it;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            if ($urandom_range(0, 1) == 0)
                fac = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            else
                fac = $urandom_range(0, NUM_FACILITIES - 1);
            if (!fac_loaded[fac]) begin
                fac_loaded[fac] = 1'b1;
                loaded_list.push_back(fac);
            end
            it = mk_item(KIND_LOAD, FAC_W'(fac), pick_capacity(), $urandom, CAP_W'($urandom),
                         $urandom, 1'($urandom));
        end else if (pick < 9) begin
            it = mk_item(KIND_RESTART, FAC_W'($urandom), CAP_W'($urandom), $urandom,
                         CAP_W'($urandom), $urandom, 1'($urandom));
        end else begin
            it = mk_item(KIND_UNUSED, FAC_W'($urandom), CAP_W'($urandom), $urandom,
                         CAP_W'($urandom), $urandom, 1'($urandom));
        end
        send_checked(it);
        rest_sender();
    endtask

    // One customer: 1 to 6 cost items over loaded facilities, ending on tlast.
    // Now and then a stray transaction or a changed demand lands mid-row.
    task automatic random_row();
        int               len;
        logic [CAP_W-1:0] dem;
        t_item            it;
        len = $urandom_range(1, 6);
        dem = pick_demand();
        for (int i = 0; i < len; i++) begin
            if (i != 0 && $urandom_range(0, 9) == 0)
                stray_item();
            it = mk_item(KIND_COST, FAC_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
                         CAP_W'($urandom), $urandom,
                         ($urandom_range(0, 9) == 0) ? pick_demand() : dem,
                         pick_travel(), i == len - 1);
            send_checked(it);
            rest_sender();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off so that the
    // result register fills and the block back-pressures its input.
    // ------------------------------------------------------------------
    initial begin : sink
        bit held_off;
        held_off = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && !held_off && assignments_seen >= 40) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Result monitor: every accepted transaction is matched against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_assign_res want;
        t_assign_res got;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.fac   = o_m_axis_tdata[10:0];
            got.total = o_m_axis_tdata[58:11];
            got.found = o_m_axis_tuser[0];
            got.fresh = o_m_axis_tuser[1];
            assignments_seen++;
            if (pending_assignments.size() == 0) begin
                $error("unexpected result transaction: facility %0d total %0h",
                       got.fac, got.total);
                mismatches++;
            end else begin
                want = pending_assignments.pop_front();
                if (got.fac !== want.fac) begin
                    $error("chosen_facility: expected %0d, got %0d", want.fac, got.fac);
                    mismatches++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, got.found);
                    mismatches++;
                end
                if (got.fresh !== want.fresh) begin
                    $error("newly_opened: expected %0b, got %0b", want.fresh, got.fresh);
                    mismatches++;
                end
                if (got.total !== want.total) begin
                    $error("total_cost: expected %0h, got %0h", want.total, got.total);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row   plan [21];
        t_assign_res r;
        int          random_start;

        for (int f = 0; f < NUM_FACILITIES; f++) begin
            cap_left[f]   = '0;
            open_cost[f]  = '0;
            fac_open[f]   = 1'b0;
            fac_loaded[f] = 1'b0;
        end
        best_travel = '1;
        best_fac    = '0;
        have_pick   = 1'b0;
        total_cost  = '0;

        // Directed table. Facilities 0, 5 and 2047 are loaded with extreme records.
        plan[0]  = '{mk_item(KIND_RESTART, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        // unused kind with every field at all ones: dropped, even with tlast
        plan[1]  = '{mk_item(KIND_UNUSED, '1, '1, '1, '1, '1, 1), 1'b0, '0};
        plan[2]  = '{mk_item(KIND_LOAD, 0, '1, '1, 0, 0, 0), 1'b0, '0};
        plan[3]  = '{mk_item(KIND_LOAD, '1, 0, 0, 0, 0, 0), 1'b0, '0};
        plan[4]  = '{mk_item(KIND_LOAD, 5, 100, 32'h100, 0, 0, 0), 1'b0, '0};
        // first candidate wins even at all-ones travel cost
        plan[5]  = '{mk_item(KIND_COST, 0, 0, 0, '1, '1, 0), 1'b0, '0};
        plan[6]  = '{mk_item(KIND_COST, '1, 0, 0, '1, 0, 1), 1'b1,
                     mk_res(0, 1, 1, 48'hFFFF_FFFF)};
        // facility 0 is drained: nothing fits
        plan[7]  = '{mk_item(KIND_COST, 0, 0, 0, 1, 0, 1), 1'b1,
                     mk_res(0, 0, 0, 48'hFFFF_FFFF)};
        // tie on travel cost keeps the earlier facility
        plan[8]  = '{mk_item(KIND_COST, '1, 0, 0, 0, 32'h80, 0), 1'b0, '0};
        plan[9]  = '{mk_item(KIND_COST, 5, 0, 0, 0, 32'h80, 1), 1'b1,
                     mk_res('1, 1, 1, 48'hFFFF_FFFF)};
        plan[10] = '{mk_item(KIND_RESTART, '1, '1, '1, '1, '1, 1), 1'b0, '0};
        plan[11] = '{mk_item(KIND_COST, 5, 0, 0, 100, 7, 1), 1'b1, mk_res(5, 1, 1, 48'h100)};
        // already open: no setup cost added
        plan[12] = '{mk_item(KIND_COST, 5, 0, 0, 0, 3, 1), 1'b1, mk_res(5, 1, 0, 48'h100)};
        plan[13] = '{mk_item(KIND_COST, 0, 0, 0, 0, 0, 1), 1'b1, mk_res(0, 1, 0, 48'h100)};
        plan[14] = '{mk_item(KIND_LOAD, 5, 50, 32'h200, 0, 0, 0), 1'b0, '0};
        // row broken up by a reload, a restart and an unused kind; the
        // reload closes facility 5 again and shrinks it below the row-end demand
        plan[15] = '{mk_item(KIND_COST, 5, 0, 0, 40, 1, 0), 1'b0, '0};
        plan[16] = '{mk_item(KIND_LOAD, 5, 10, 32'h200, 0, 0, 0), 1'b0, '0};
        plan[17] = '{mk_item(KIND_RESTART, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        plan[18] = '{mk_item(KIND_UNUSED, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        plan[19] = '{mk_item(KIND_COST, 0, 0, 0, 60, 9, 1), 1'b1, mk_res(5, 1, 1, 48'h200)};
        plan[20] = '{mk_item(KIND_COST, '1, 0, 0, 0, '1, 1), 1'b1, mk_res('1, 1, 0, 48'h200)};

        // synchronous reset first, then the block runs its clearing pass
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            offer(plan[i].item);
            if (assign_step(plan[i].item, r))
                pending_assignments.push_back(plan[i].pinned ? plan[i].want : r);
            rest_sender();
        end
        fac_loaded[0]    = 1'b1;
        fac_loaded[5]    = 1'b1;
        fac_loaded[2047] = 1'b1;
        loaded_list      = '{0, 5, 2047};

        // random part: mostly well-formed customer rows, some strays
        random_start = counted_items;
        while (counted_items - random_start < RANDOM_ITEMS) begin
            calm = (counted_items - random_start >= CALM_AFTER);
            if ($urandom_range(0, 4) == 0)
                stray_item();
            else
                random_row();
        end
        calm = 1'b1;

        // back-to-back reload and open of one facility, no idling
        for (int k = 0; k < OPEN_PAIRS; k++) begin
            send_checked(mk_item(KIND_LOAD, 9, '1, '1, 0, 0, 0));
            send_checked(mk_item(KIND_COST, 9, 0, 0, 0, 0, 1));
        end
        send_checked(mk_item(KIND_RESTART, 0, 0, 0, 0, 0, 0));
        send_checked(mk_item(KIND_COST, 9, 0, 0, 0, 0, 1));
        s_valid <= 1'b0;

        while (pending_assignments.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[greedy_capacitated_facility_assign_top] OK");
        else
            $display("[greedy_capacitated_facility_assign_top] ERROR");
        $finish;
    end

    // Watchdog, well beyond the clearing pass plus the slowest correct run
    initial begin : watchdog
        #4_000_000;
        $display("[greedy_capacitated_facility_assign_top] ERROR");
        $finish;
    end

endmodule
